[rtl/core/evd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package evd_pkg;

  localparam int ByteW  = 8;
  localparam int ValueW = 56;
  localparam int LenW   = 4;
  localparam int RemW   = 3;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_READ_FAIL   = 2'd1,
    STATUS_ID_TOO_LONG = 2'd2
  } evd_status_t;

  typedef enum logic {
    KIND_ID   = 1'b0,
    KIND_SIZE = 1'b1
  } evd_kind_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             action;
    logic             read_failed;
  } evd_in_t;

  typedef struct packed {
    logic [ValueW-1:0] decoded_value;
    logic              value_kind;
    logic [LenW-1:0]   coded_length;
    logic [1:0]        status;
  } evd_out_t;

  // Handshake between the input register and the decode stage.
  typedef struct packed {
    logic    valid;
    evd_in_t item;
  } evd_stage_t;

  // Leading zero count plus one; an all-zero byte counts as length 8.
  function automatic logic [LenW-1:0] vint_len(logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    n = LenW'(ByteW);
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) begin
        n = LenW'(ByteW - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ebml_vint_stream_decoder_top.sv]
// EBML variable-length integer decoder, one stream byte per transaction.
// Input channel in_valid/in_ready/in_data carries a byte, the action
// (0 element ID, 1 element size, sampled on an element's first byte) and
// a read failure flag. Output channel out_valid/out_ready/out_data carries
// one result per element: the value (ID with marker bits, size without),
// its kind, coded length and status (ok, read failure, ID too long).
// Bytes that are not the last of an element produce no transaction.
// A byte sits in the input register, then the decode logic loads the
// result register, which raises out_valid. Throughput: one byte per
// clock while the receiver does not stall, set by the single decode
// stage; bytes of an element are shifted into the value register one
// per cycle.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for an element's first byte.
// When the receiver stalls, the held result stays on out_data, at most
// one more byte is taken into the input register, and then in_ready drops
// until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module ebml_vint_stream_decoder_top
  import evd_pkg::*;
#(
  parameter int MAX_ID_BYTES = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire evd_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output evd_out_t     out_data
);

  evd_stage_t stage;
  logic       take;

  evd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stage    (stage),
    .take     (take)
  );

  evd_decode #(
    .MAX_ID_BYTES (MAX_ID_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/core/evd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module evd_in_stage
  import evd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire evd_in_t    in_data,
  output evd_stage_t      stage,
  input  wire logic       take
);

  logic    valid_r, valid_nxt;
  evd_in_t item_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

`default_nettype wire

[rtl/core/evd_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module evd_decode
  import evd_pkg::*;
#(
  parameter int MAX_ID_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire evd_stage_t stage,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output evd_out_t        out_data
);

  localparam logic [LenW-1:0] MaxIdLen = LenW'(MAX_ID_BYTES);

  logic [RemW-1:0]   rem_r, rem_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              kind_r, kind_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  evd_out_t          out_r;

  logic              emit;
  evd_out_t          res;
  logic [LenW-1:0]   first_len, first_len_m1;
  logic [ByteW-1:0]  first_mask, first_val;
  logic [ValueW-1:0] shifted;
  logic [ByteW-1:0]  b;

  // Consume when the result register is free or being drained this cycle.
  assign take = stage.valid && (!out_valid_r || out_ready);
  assign b    = stage.item.data_byte;

  always_comb begin
    first_len    = vint_len(b);
    first_len_m1 = first_len - LenW'(1);
    first_mask   = ByteW'(8'hFF >> first_len);
    first_val    = stage.item.action ? (b & first_mask) : b;
    shifted      = {acc_r[ValueW-ByteW-1:0], b};
  end

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    kind_nxt = kind_r;
    len_nxt  = len_r;
    emit     = 1'b0;
    res      = '0;
    if (take) begin
      if (rem_r == '0) begin
        if (stage.item.read_failed) begin
          emit           = 1'b1;
          res.value_kind = stage.item.action;
          res.status     = STATUS_READ_FAIL;
        end else if (stage.item.action == KIND_ID && first_len > MaxIdLen) begin
          emit             = 1'b1;
          res.value_kind   = KIND_ID;
          res.coded_length = first_len;
          res.status       = STATUS_ID_TOO_LONG;
        end else if (first_len == LenW'(1)) begin
          emit              = 1'b1;
          res.decoded_value = ValueW'(first_val);
          res.value_kind    = stage.item.action;
          res.coded_length  = first_len;
          res.status        = STATUS_OK;
        end else begin
          rem_nxt  = first_len_m1[RemW-1:0];
          acc_nxt  = ValueW'(first_val);
          kind_nxt = stage.item.action;
          len_nxt  = first_len;
        end
      end else begin
        if (stage.item.read_failed) begin
          emit             = 1'b1;
          res.value_kind   = kind_r;
          res.coded_length = len_r;
          res.status       = STATUS_READ_FAIL;
          rem_nxt          = '0;
        end else begin
          acc_nxt = shifted;
          rem_nxt = rem_r - RemW'(1);
          if (rem_r == RemW'(1)) begin
            emit              = 1'b1;
            res.decoded_value = shifted;
            res.value_kind    = kind_r;
            res.coded_length  = len_r;
            res.status        = STATUS_OK;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    kind_r <= kind_nxt;
    len_r  <= len_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Never overwrite a result the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !emit)
    else $error("result overwritten while stalled");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    take && rem_r > RemW'(1) && !stage.item.read_failed
      |=> rem_r == $past(rem_r) - RemW'(1))
    else $error("byte counter skipped");

  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    take && rem_r == RemW'(1) && !stage.item.read_failed
      |=> out_valid_r && out_r.status == STATUS_OK && rem_r == '0)
    else $error("last byte gave no result");

  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STATUS_ID_TOO_LONG
      |-> out_r.value_kind == KIND_ID && out_r.coded_length > MaxIdLen
          && out_r.decoded_value == '0)
    else $error("bad ID length error result");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STATUS_OK
      |-> out_r.coded_length >= LenW'(1) && out_r.coded_length <= LenW'(ByteW))
    else $error("ok result with bad length");

endmodule

`default_nettype wire
